@@ hw/rtl/integer_set_table_macros.svh @@
// ----------------------------------------------------------------------------
// integer_set_table assertion macros
// Concurrent assertion wrappers sampled on clk with rst_n as the disable.
// ----------------------------------------------------------------------------
`ifndef INTEGER_SET_TABLE_MACROS_SVH
`define INTEGER_SET_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define IST_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IST_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) not (cond)) else $error(msg);
`else
`define IST_ASSERT(name, prop, msg)
`define IST_ASSERT_NEVER(name, cond, msg)
`endif
`endif

@@ hw/rtl/ist_pkg.sv @@
// ----------------------------------------------------------------------------
// ist_pkg
// Shared constants, operation codes and control/status types of the set table.
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 7;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [OP_W-1:0] CMD_INSERT      = 2'd0;
    localparam logic [OP_W-1:0] CMD_REMOVE      = 2'd1;
    localparam logic [OP_W-1:0] CMD_CONTAINS    = 2'd2;
    localparam logic [OP_W-1:0] CMD_REMOVE_LAST = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic scan_rd;
        logic pop_rd;
        logic commit;
    } ist_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic            rd_more;
        logic            dv;
        logic            hit;
        logic            out_free;
        logic [OP_W-1:0] op;
    } ist_sts_t;

endpackage

@@ hw/rtl/ist_if.sv @@
// ----------------------------------------------------------------------------
// ist_if
// Request and response channel interfaces, valid/ready with payload.
// ----------------------------------------------------------------------------
interface ist_req_if
    import ist_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          cmd;
    logic signed [DATA_W-1:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface ist_rsp_if
    import ist_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     found;
    logic signed [DATA_W-1:0] value_out;
    logic [COUNT_W-1:0]       count;
    logic                     dropped;

    modport source (output valid, output found, output value_out, output count,
                    output dropped, input ready);
    modport sink   (input valid, input found, input value_out, input count,
                    input dropped, output ready);
endinterface

@@ hw/rtl/ist_dp.sv @@
// ----------------------------------------------------------------------------
// ist_dp
// Entry memory, count, scan pointers, key compare and response register.
// ----------------------------------------------------------------------------
`include "integer_set_table_macros.svh"

module ist_dp
    import ist_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ist_cmd_t           cmd,
    output ist_sts_t           sts,
    input  logic [OP_W-1:0]    req_cmd,
    input  logic [DATA_W-1:0]  req_key,
    ist_rsp_if.source          rsp
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] key_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic [ADDR_W-1:0] rd_pos_reg;
    logic              dv_reg;
    logic              found_reg;

    logic              out_valid_reg;
    logic              out_found_reg, out_found_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic              out_dropped_reg, out_dropped_next;
    logic [CNT_W-1:0]  out_count_reg;

    logic              full;
    logic              hit;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              shift_we, ins_we;
    logic [ADDR_W-1:0] last_idx;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign hit      = dv_reg && (rdata_reg == key_reg);
    assign last_idx = ADDR_W'(count_reg - CNT_W'(1));

    assign sts.rd_more  = (rd_idx_reg < count_reg);
    assign sts.dv       = dv_reg;
    assign sts.hit      = hit;
    assign sts.out_free = !out_valid_reg || rsp.ready;
    assign sts.op       = op_reg;

    // once the key has been seen, every later entry moves down one place
    assign shift_we = cmd.scan && dv_reg && found_reg && (op_reg == CMD_REMOVE);
    assign ins_we   = cmd.commit && (op_reg == CMD_INSERT) && !found_reg && !full;

    always_comb
    begin
        mem_we    = shift_we || ins_we;
        mem_waddr = shift_we ? (rd_pos_reg - ADDR_W'(1)) : count_reg[ADDR_W-1:0];
        mem_wdata = shift_we ? rdata_reg : key_reg;
        mem_re    = cmd.scan_rd || (cmd.pop_rd && (count_reg != '0));
        mem_raddr = cmd.scan_rd ? rd_idx_reg[ADDR_W-1:0] : last_idx;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        count_next       = count_reg;
        out_found_next   = found_reg;
        out_value_next   = '0;
        out_dropped_next = 1'b0;
        case (op_reg)
            CMD_INSERT:
            begin
                if (!found_reg)
                begin
                    if (full)
                    begin
                        out_dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (found_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_CONTAINS:
            begin
                count_next = count_reg;
            end
            CMD_REMOVE_LAST:
            begin
                out_found_next = (count_reg != '0);
                if (count_reg != '0)
                begin
                    count_next     = count_reg - CNT_W'(1);
                    out_value_next = rdata_reg;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= CMD_INSERT;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            dv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                op_reg     <= req_cmd;
                rd_idx_reg <= '0;
                dv_reg     <= 1'b0;
                found_reg  <= 1'b0;
            end
            if (cmd.scan)
            begin
                dv_reg <= cmd.scan_rd;
                if (cmd.scan_rd)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= req_key;
        end
        if (cmd.scan_rd)
        begin
            rd_pos_reg <= rd_idx_reg[ADDR_W-1:0];
        end
        if (cmd.commit)
        begin
            out_found_reg   <= out_found_next;
            out_value_reg   <= out_value_next;
            out_dropped_reg <= out_dropped_next;
            out_count_reg   <= count_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.found     = out_found_reg;
    assign rsp.value_out = $signed(out_value_reg);
    assign rsp.count     = COUNT_W'(out_count_reg);
    assign rsp.dropped   = out_dropped_reg;

    `IST_ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(CAPACITY), "count beyond capacity")
    `IST_ASSERT(a_insert_grows, ins_we |=> count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow count")
    `IST_ASSERT(a_pop_empty, cmd.commit && (op_reg == CMD_REMOVE_LAST) && (count_reg == '0) |=> !out_found_reg && (out_value_reg == '0), "pop on empty table not zero")

endmodule

@@ hw/rtl/ist_ctrl.sv @@
// ----------------------------------------------------------------------------
// ist_ctrl
// Request sequencer: accept, scan or pop, then commit into the response beat.
// ----------------------------------------------------------------------------
`include "integer_set_table_macros.svh"

module ist_ctrl
    import ist_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_is_pop,
    output logic     ready,
    output ist_cmd_t cmd,
    input  ist_sts_t sts
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_POP    = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       scan_done;

    // a remove keeps going past the hit so the tail can be shifted down
    assign scan_done = (!sts.dv && !sts.rd_more) || (sts.hit && (sts.op != CMD_REMOVE));
    assign ready     = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = req_is_pop ? S_POP : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (scan_done)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.scan_rd = sts.rd_more;
                end
            end
            S_POP:
            begin
                cmd.pop_rd = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `IST_ASSERT(a_pop_to_commit, state_reg == S_POP |=> state_reg == S_COMMIT, "pop read not followed by commit")
    `IST_ASSERT(a_commit_to_idle, cmd.commit |=> state_reg == S_IDLE, "commit did not return to idle")
    `IST_ASSERT(a_accept_pop, (state_reg == S_IDLE) && req_valid && req_is_pop |=> state_reg == S_POP, "pop request not routed")

endmodule

@@ hw/rtl/integer_set_table.sv @@
// ----------------------------------------------------------------------------
// integer_set_table
// Ordered table of distinct signed 32-bit keys with insert, remove, lookup
// and remove-last, one response beat per request beat.
//
// Channels: req carries cmd and key; rsp carries found, value_out, count and
// dropped. Both are valid/ready; a beat moves when both are high.
// One request is worked at a time; req.ready is high only while idle.
// Insert, remove and contains scan the entry memory one word a cycle through
// its single registered read port, then commit; the next request is taken
// once the commit has returned the sequencer to idle. A lookup or an insert
// that hits stops early. A remove writes the shifted tail back during the
// same pass. Remove-last reads the final entry directly in its pop state
// and then commits.
// The result sits in an output register, so the next request is taken while
// a response waits; a stalled rsp holds its beat and blocks only the commit
// of the following request.
// Reset empties the table at once (count to zero); no clearing pass is run.
// ----------------------------------------------------------------------------
module integer_set_table
    import ist_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ist_req_if.sink  req,
    ist_rsp_if.source rsp
);

    ist_cmd_t cmd;
    ist_sts_t sts;
    logic     ready;

    assign req.ready = ready;

    ist_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_is_pop (req.cmd == CMD_REMOVE_LAST),
        .ready      (ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    ist_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .req_cmd (req.cmd),
        .req_key ($unsigned(req.key)),
        .rsp     (rsp)
    );

endmodule
